@@ hw/rtl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// First-fit allocator package
// Shared constants and codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int DEF_ARENA_BYTES  = 4096;
  localparam int DEF_HEADER_BYTES = 8;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int RES_W     = 12;

  localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

  localparam logic [CFG_W-1:0] REQ_FLOOR_RST = 12'd8;
  localparam logic [CFG_W-1:0] SPLIT_THR_RST = 12'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_REQ_FLOOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_THR = 1'b1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage

@@ hw/rtl/ffba_hdr_store.sv @@
// ----------------------------------------------------------------------------
// Block header store
// One header per byte offset: an in-use bit above the block size. Read data
// is registered. Entry 0 reads as one free block spanning the arena until it
// is first written.
// ----------------------------------------------------------------------------
module ffba_hdr_store
  import ffba_pkg::*;
#(
  parameter int ARENA_BYTES  = DEF_ARENA_BYTES,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [$clog2(ARENA_BYTES)-1:0]  rd_addr,
  output logic [$clog2(ARENA_BYTES):0]    rd_data,
  input  logic                            wr_en,
  input  logic [$clog2(ARENA_BYTES)-1:0]  wr_addr,
  input  logic [$clog2(ARENA_BYTES):0]    wr_data
);

  localparam int AW = $clog2(ARENA_BYTES);
  localparam logic [AW:0] HDR0_RST = {1'b0, AW'(ARENA_BYTES - HEADER_BYTES)};

  logic [AW:0] mem [ARENA_BYTES];
  logic [AW:0] rd_q_r;
  logic        hdr0_written_r;
  logic        rd_rst_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr0_written_r <= 1'b0;
      rd_rst_r       <= 1'b0;
    end else begin
      if (wr_en && (wr_addr == '0)) begin
        hdr0_written_r <= 1'b1;
      end
      rd_rst_r <= (rd_addr == '0) && !hdr0_written_r;
    end
  end

  assign rd_data = rd_rst_r ? HDR0_RST : rd_q_r;

endmodule

@@ hw/rtl/first_fit_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// First-fit block allocator
// Allocates and frees blocks in an arena of in-band headers. A sequencer
// walks the header chain one header per cycle.
//
//   channel  | direction | handshake           | payload
//   in_      | input     | in_valid / in_stall | in_cmd, in_req_size, in_user_offset
//   out_     | output    | out_valid/out_stall | out_ok, out_result_offset, out_used_bytes
//   cfg_     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Allocate reads headers in turn from offset 0 until a free block fits and
// writes the split header first when the block is split. Free reads its own
// header, then each following header while merging; a null or out-of-range
// offset goes straight to the result. The header walk sets the worst case.
// Reset is synchronous and needs no clearing pass over the header store.
// A stalled result holds in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int ARENA_BYTES  = DEF_ARENA_BYTES,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [11:0]          in_req_size,
  input  logic [11:0]          in_user_offset,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_ok,
  output logic [RES_W-1:0]     out_result_offset,
  output logic [RES_W-1:0]     out_used_bytes,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int WW = ((AW > CFG_W) ? AW : CFG_W) + 2;
  localparam int TW = AW + 1;
  localparam int SW = (TW > RES_W) ? TW : RES_W;
  localparam logic [WW-1:0] HDR_W   = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] ARENA_W = WW'(ARENA_BYTES);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_A_RD  = 3'd1;
  localparam logic [2:0] ST_A_CHK = 3'd2;
  localparam logic [2:0] ST_A_SET = 3'd3;
  localparam logic [2:0] ST_F_RD  = 3'd4;
  localparam logic [2:0] ST_F_CHK = 3'd5;
  localparam logic [2:0] ST_F_MRG = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [WW-1:0]    pos_r, pos_nxt;
  logic [WW-1:0]    blk_r, blk_nxt;
  logic [WW-1:0]    want_r, want_nxt;
  logic [WW-1:0]    split_r, split_nxt;
  logic [TW-1:0]    total_r, total_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [RES_W-1:0] res_off_r, res_off_nxt;
  logic [CFG_W-1:0] req_floor_r;
  logic [CFG_W-1:0] split_thr_r;
  logic             out_valid_r;
  logic             out_ok_r;
  logic [RES_W-1:0] out_off_r;
  logic [RES_W-1:0] out_used_r;

  logic [AW-1:0]    rd_addr;
  logic [AW:0]      rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW:0]      wr_data;

  logic             rd_used;
  logic [WW-1:0]    rd_size;
  logic [TW-1:0]    rd_size_ext;
  logic [WW-1:0]    sum;
  logic             fits;
  logic             do_split;
  logic [WW-1:0]    split_addr;
  logic [WW-1:0]    split_size;
  logic [WW-1:0]    merge_end;
  logic [WW-1:0]    merge_size;
  logic [CFG_W-1:0] want_in;
  logic [WW-1:0]    split_in;
  logic [WW-1:0]    uoff_w;
  logic [WW-1:0]    blk_in;
  logic             free_bad;
  logic             out_load;
  logic [SW-1:0]    total_ext;

  ffba_hdr_store #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign rd_used     = rd_data[AW];
  assign rd_size     = WW'(rd_data[AW-1:0]);
  assign rd_size_ext = TW'(rd_data[AW-1:0]);
  assign sum         = pos_r + HDR_W + rd_size;
  assign fits        = !rd_used && (rd_size >= want_r);
  assign do_split    = rd_size >= (want_r + split_r);
  assign split_addr  = pos_r + HDR_W + want_r;
  assign split_size  = rd_size - want_r - HDR_W;
  assign merge_end   = ((state_r == ST_F_MRG) && rd_used) ? pos_r : sum;
  assign merge_size  = merge_end - blk_r - HDR_W;

  assign want_in  = (in_req_size < req_floor_r) ? req_floor_r : in_req_size;
  assign split_in = (WW'(split_thr_r) < HDR_W) ? HDR_W : WW'(split_thr_r);
  assign uoff_w   = WW'(in_user_offset);
  assign blk_in   = uoff_w - HDR_W;
  assign free_bad = (uoff_w < HDR_W) || (blk_in >= ARENA_W);

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    blk_nxt     = blk_r;
    want_nxt    = want_r;
    split_nxt   = split_r;
    total_nxt   = total_r;
    res_ok_nxt  = res_ok_r;
    res_off_nxt = res_off_r;
    rd_addr     = pos_r[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pos_r[AW-1:0];
    wr_data     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          want_nxt    = WW'(want_in);
          split_nxt   = split_in;
          res_ok_nxt  = 1'b0;
          res_off_nxt = '0;
          if (in_cmd == CMD_ALLOC) begin
            pos_nxt   = '0;
            state_nxt = ST_A_RD;
          end else if (free_bad) begin
            state_nxt = ST_DONE;
          end else begin
            pos_nxt   = blk_in;
            blk_nxt   = blk_in;
            state_nxt = ST_F_RD;
          end
        end
      end
      ST_A_RD: begin
        state_nxt = ST_A_CHK;
      end
      ST_A_CHK: begin
        if (fits) begin
          if (do_split) begin
            wr_en     = 1'b1;
            wr_addr   = split_addr[AW-1:0];
            wr_data   = {1'b0, split_size[AW-1:0]};
            state_nxt = ST_A_SET;
          end else begin
            wr_en       = 1'b1;
            wr_data     = {1'b1, rd_data[AW-1:0]};
            total_nxt   = total_r + rd_size_ext;
            res_ok_nxt  = 1'b1;
            res_off_nxt = split_addr[RES_W-1:0] - want_r[RES_W-1:0];
            state_nxt   = ST_DONE;
          end
        end else begin
          pos_nxt = sum;
          rd_addr = sum[AW-1:0];
          if (sum >= ARENA_W) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_A_SET: begin
        wr_en       = 1'b1;
        wr_data     = {1'b1, want_r[AW-1:0]};
        total_nxt   = total_r + TW'(want_r[AW-1:0]);
        res_ok_nxt  = 1'b1;
        res_off_nxt = split_addr[RES_W-1:0] - want_r[RES_W-1:0];
        state_nxt   = ST_DONE;
      end
      ST_F_RD: begin
        state_nxt = ST_F_CHK;
      end
      ST_F_CHK: begin
        res_ok_nxt = 1'b1;
        if (!rd_used) begin
          state_nxt = ST_DONE;
        end else begin
          total_nxt = (total_r >= rd_size_ext) ? (total_r - rd_size_ext) : '0;
          pos_nxt   = sum;
          rd_addr   = sum[AW-1:0];
          if (sum >= ARENA_W) begin
            wr_en     = 1'b1;
            wr_addr   = blk_r[AW-1:0];
            wr_data   = {1'b0, merge_size[AW-1:0]};
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_F_MRG;
          end
        end
      end
      ST_F_MRG: begin
        if (rd_used || (sum >= ARENA_W)) begin
          wr_en     = 1'b1;
          wr_addr   = blk_r[AW-1:0];
          wr_data   = {1'b0, merge_size[AW-1:0]};
          state_nxt = ST_DONE;
        end else begin
          pos_nxt = sum;
          rd_addr = sum[AW-1:0];
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign total_ext = SW'(total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      req_floor_r <= REQ_FLOOR_RST;
      split_thr_r <= SPLIT_THR_RST;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_REQ_FLOOR: req_floor_r <= cfg_data;
          CFG_SPLIT_THR: split_thr_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    blk_r     <= blk_nxt;
    want_r    <= want_nxt;
    split_r   <= split_nxt;
    res_ok_r  <= res_ok_nxt;
    res_off_r <= res_off_nxt;
    if (out_load) begin
      out_ok_r   <= res_ok_r;
      out_off_r  <= res_off_r;
      out_used_r <= (total_ext > SW'(RES_MAX)) ? RES_MAX : total_ext[RES_W-1:0];
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_result_offset = out_off_r;
  assign out_used_bytes    = out_used_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted but sequencer did not start");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((state_r == ST_A_CHK) || (state_r == ST_A_SET) ||
               (state_r == ST_F_CHK) || (state_r == ST_F_MRG)))
    else $error("header write outside a writing step");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_A_CHK) |-> (pos_r < ARENA_W))
    else $error("header walk left the arena");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && !res_ok_r) |-> (res_off_r == '0))
    else $error("failed item carries a nonzero offset");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result presented without a finished item");

endmodule

@@ test/first_fit_block_allocator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// First-fit block allocator testbench
// Drives allocate and free items through the unit under random idling and
// back-pressure, predicts each result from a shadow copy of the header store
// and the running total, and checks every result field in order. The run
// moves through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  localparam int ARENA     = DEF_ARENA_BYTES;
  localparam int HDR       = DEF_HEADER_BYTES;
  localparam int LIMIT     = 10000000;
  localparam int N_PHASE   = 9;
  localparam int IDLE_PCT  = 29;
  localparam int HOLD_LEN  = 3000;
  localparam int DRAIN_LEN = 600;

  typedef struct packed {
    logic             cmd;
    logic [11:0]      req_size;
    logic [11:0]      user_offset;
  } heap_op_t;

  typedef struct packed {
    logic             ok;
    logic [RES_W-1:0] result_offset;
    logic [RES_W-1:0] used_bytes;
  } heap_reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd = CMD_ALLOC;
  logic [11:0]          in_req_size = '0;
  logic [11:0]          in_user_offset = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_ok;
  logic [RES_W-1:0]     out_result_offset;
  logic [RES_W-1:0]     out_used_bytes;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_REQ_FLOOR;
  logic [CFG_W-1:0]     cfg_data = '0;

  first_fit_block_allocator_unit #(
    .ARENA_BYTES (ARENA),
    .HEADER_BYTES(HDR)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_req_size      (in_req_size),
    .in_user_offset   (in_user_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_result_offset(out_result_offset),
    .out_used_bytes   (out_used_bytes),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the allocator state.
  int unsigned blk_size [0:ARENA-1];
  bit          blk_busy [0:ARENA-1];
  bit          hdr_written [0:ARENA-1];
  int unsigned used_sum = 0;
  logic [11:0] req_floor = REQ_FLOOR_RST;
  logic [11:0] split_thr = SPLIT_THR_RST;

  // Offsets the stimulus may legally free.
  logic [11:0] live_offsets[$];
  int unsigned header_spots[$];

  heap_op_t    pending_ops[$];
  heap_reply_t expected_replies[$];
  int          replies_due = 0;
  int          ops_pushed = 0;
  int          ops_taken = 0;
  bit          op_taken = 1'b0;
  bit          calm = 1'b0;
  bit          rx_hold = 1'b0;
  int          errors = 0;
  int          cycle_count = 0;

  task automatic log_mismatch(input string what, input int got, input int want);
    if (errors < 40) begin
      $display("mismatch: %s got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    end
    errors++;
  endtask

  function automatic heap_reply_t apply_heap_op(input heap_op_t op);
    heap_reply_t r;
    int unsigned want, split_min, pos, bsize, n, blk;
    bit          found;
    r = '0;
    if (op.cmd == CMD_ALLOC) begin
      want = (op.req_size < req_floor) ? req_floor : op.req_size;
      split_min = (split_thr < HDR) ? HDR : split_thr;
      pos = 0;
      found = 1'b0;
      while (!found && pos < ARENA) begin
        bsize = blk_size[pos % ARENA];
        if (!blk_busy[pos % ARENA] && bsize >= want) begin
          if (bsize >= want + split_min) begin
            n = (pos + HDR + want) % ARENA;
            blk_size[n] = bsize - want - HDR;
            blk_busy[n] = 1'b0;
            if (!hdr_written[n]) begin
              hdr_written[n] = 1'b1;
              if (n + HDR < ARENA) header_spots.push_back(n);
            end
            blk_size[pos % ARENA] = want;
          end
          blk_busy[pos % ARENA] = 1'b1;
          used_sum += blk_size[pos % ARENA];
          r.ok = 1'b1;
          r.result_offset = 12'(pos + HDR);
          live_offsets.push_back(r.result_offset);
          found = 1'b1;
        end else begin
          pos += HDR + bsize;
        end
      end
    end else if (op.user_offset >= HDR && op.user_offset - HDR < ARENA) begin
      blk = op.user_offset - HDR;
      r.ok = 1'b1;
      if (blk_busy[blk]) begin
        blk_busy[blk] = 1'b0;
        used_sum = (used_sum >= blk_size[blk]) ? used_sum - blk_size[blk] : 0;
        foreach (live_offsets[i]) begin
          if (live_offsets[i] == op.user_offset) begin
            live_offsets.delete(i);
            break;
          end
        end
        pos = blk + HDR + blk_size[blk];
        while (pos < ARENA && !blk_busy[pos]) begin
          bsize = blk_size[pos];
          blk_size[blk] += HDR + bsize;
          pos += HDR + bsize;
        end
      end
    end
    r.used_bytes = (used_sum > RES_MAX) ? RES_MAX : RES_W'(used_sum);
    return r;
  endfunction

  function automatic heap_op_t random_op();
    heap_op_t op;
    int       roll, pick, free_pct;
    op.cmd = CMD_ALLOC;
    op.req_size = 12'($urandom);
    op.user_offset = 12'($urandom);
    roll = $urandom_range(0, 99);
    free_pct = (live_offsets.size() > 40) ? 70 : 45;
    if ((live_offsets.size() > 0 && roll < free_pct) || roll < 4) begin
      op.cmd = CMD_FREE;
      pick = $urandom_range(0, 99);
      if (pick < 80 && live_offsets.size() > 0) begin
        op.user_offset = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
      end else if (pick < 93) begin
        op.user_offset = 12'(header_spots[$urandom_range(0, header_spots.size() - 1)] + HDR);
      end else if (pick < 96) begin
        op.user_offset = '0;
      end else begin
        op.user_offset = 12'($urandom_range(1, HDR - 1));
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) op.req_size = 12'($urandom_range(0, 48));
      else if (pick < 90) op.req_size = 12'($urandom_range(0, 400));
    end
    return op;
  endfunction

  // Queues one item and returns once the unit has taken it, so that the next
  // item is built from up-to-date shadow state.
  task automatic issue(input heap_op_t op);
    calm = (ops_pushed >= 900 && ops_pushed < 1100);
    pending_ops.push_back(op);
    ops_pushed++;
    wait (ops_taken == ops_pushed);
  endtask

  task automatic set_limits(input logic [11:0] alloc_min, input logic [11:0] split_min);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_REQ_FLOOR;
    cfg_data  <= alloc_min;
    do @(posedge clk); while (!cfg_ready);
    req_floor = alloc_min;
    @(negedge clk);
    cfg_index <= CFG_SPLIT_THR;
    cfg_data  <= split_min;
    do @(posedge clk); while (!cfg_ready);
    split_thr = split_min;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Driver: a new item is offered only once the previous one was taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || op_taken)) begin
      op_taken = 1'b0;
      if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        heap_op_t op;
        op = pending_ops.pop_front();
        in_valid       <= 1'b1;
        in_cmd         <= op.cmd;
        in_req_size    <= op.req_size;
        in_user_offset <= op.user_offset;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rx_hold || (!calm && $urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_replies.push_back(apply_heap_op('{in_cmd, in_req_size, in_user_offset}));
      replies_due = expected_replies.size();
      op_taken = 1'b1;
      ops_taken++;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        log_mismatch("unexpected result, offset", out_result_offset, 0);
      end else begin
        heap_reply_t want;
        want = expected_replies.pop_front();
        replies_due = expected_replies.size();
        if (out_ok !== want.ok) log_mismatch("ok", out_ok, want.ok);
        if (out_result_offset !== want.result_offset) begin
          log_mismatch("result_offset", out_result_offset, want.result_offset);
        end
        if (out_used_bytes !== want.used_bytes) begin
          log_mismatch("used_bytes", out_used_bytes, want.used_bytes);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver holds off long enough for the unit to back up into its input.
  initial begin
    wait (ops_pushed >= 500);
    rx_hold = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    int          phase_items [N_PHASE] = '{220, 200, 200, 150, 60, 200, 150, 200, 200};
    logic [11:0] alloc_set [N_PHASE] = '{12'd8, 12'd1, 12'd0, 12'd64, 12'd4095,
                                         12'd24, 12'd2, 12'd12, 12'd1};
    logic [11:0] split_set [N_PHASE] = '{12'd16, 12'd8, 12'd0, 12'd4095, 12'd3,
                                         12'd40, 12'd4095, 12'd8, 12'd16};
    blk_size[0] = ARENA - HDR;
    hdr_written[0] = 1'b1;
    header_spots.push_back(0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue('{CMD_FREE, 12'd0, 12'd0});
    issue('{CMD_FREE, 12'd0, 12'd7});
    issue('{CMD_FREE, 12'hfff, 12'd1});
    issue('{CMD_ALLOC, 12'd0, 12'hfff});
    issue('{CMD_ALLOC, 12'd4095, 12'd0});
    issue('{CMD_ALLOC, 12'd100, 12'd0});
    issue('{CMD_ALLOC, 12'd5, 12'd0});
    issue('{CMD_FREE, 12'd0, 12'd8});
    issue('{CMD_FREE, 12'd0, 12'd8});
    issue('{CMD_ALLOC, 12'd8, 12'd0});
    issue('{CMD_FREE, 12'd0, 12'd132});
    issue('{CMD_FREE, 12'd0, 12'd24});
    issue('{CMD_FREE, 12'd0, 12'd8});
    issue('{CMD_ALLOC, 12'd4088, 12'd0});
    issue('{CMD_ALLOC, 12'd1, 12'd0});
    issue('{CMD_FREE, 12'd0, 12'd8});
    issue('{CMD_ALLOC, 12'd4072, 12'd0});
    issue('{CMD_FREE, 12'd0, 12'd8});
    issue('{CMD_ALLOC, 12'd4073, 12'd0});
    issue('{CMD_FREE, 12'd0, 12'd116});
    issue('{CMD_FREE, 12'd0, 12'd8});

    for (int p = 0; p < N_PHASE; p++) begin
      if (p > 0) begin
        wait (replies_due == 0);
        set_limits(alloc_set[p], split_set[p]);
      end
      for (int i = 0; i < phase_items[p]; i++) begin
        issue(random_op());
      end
    end

    wait (replies_due == 0);
    repeat (DRAIN_LEN) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_hdr_store.sv
hw/rtl/first_fit_block_allocator_unit.sv
test/first_fit_block_allocator_unit_tb.sv
